// ===== rtl/tet_element_stiffness_unit_defines.svh =====
// Assertion macros for the element stiffness unit.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef TET_ELEMENT_STIFFNESS_UNIT_DEFINES_SVH
`define TET_ELEMENT_STIFFNESS_UNIT_DEFINES_SVH

// Same-cycle implication
`define TES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tes check failed");

// Next-cycle implication
`define TES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tes check failed");

`endif

// ===== rtl/tes_pkg.sv =====
package tes_pkg;

    localparam int NODE_W   = 20;
    localparam int COORD_W  = 32;
    localparam int COEF_W   = 32;
    localparam int DIFF_W   = 33;   // edge vector component
    localparam int OPB_W    = 72;   // register file word, multiplier B operand
    localparam int OPA_W    = 144;  // multiplier A operand
    localparam int PROD_W   = 176;  // product and accumulator
    localparam int DET_W    = 104;
    localparam int DEN_W    = 108;
    localparam int Q_W      = 64;
    localparam int VAL_W    = 64;

    localparam int FILE_DEPTH = 21;  // edge components at 0 to 8, adjugate components at 9 to 20
    localparam int FILE_AW    = 5;
    localparam int ADJ_BASE   = 9;
    localparam int ADJ3_BASE  = 18;

    localparam logic [COEF_W-1:0] COEF_RESET = 32'h0001_0000;
    localparam logic [VAL_W-1:0]  VAL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0]  VAL_MIN    = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [3:0][NODE_W-1:0]   nodes;
        logic [11:0][COORD_W-1:0] coords;
    } t_elem;

    typedef struct packed {
        logic              start;
        logic [OPA_W-1:0]  a;
        logic [OPB_W-1:0]  b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] mag;
        logic [DEN_W-1:0]  den2;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [Q_W-1:0]    q;
    } t_div_rsp;

    // Increment modulo three
    function automatic logic [1:0] f_inc3(input logic [1:0] x);
        logic [1:0] r;
        r = (x == 2'd2) ? 2'd0 : x + 2'd1;
        return r;
    endfunction

endpackage

// ===== rtl/tes_if.sv =====
interface tes_vtx_if;
    logic                              valid;
    logic                              ready;
    logic [tes_pkg::NODE_W-1:0]        node_number;
    logic signed [tes_pkg::COORD_W-1:0] coord_x;
    logic signed [tes_pkg::COORD_W-1:0] coord_y;
    logic signed [tes_pkg::COORD_W-1:0] coord_z;

    modport source (output valid, node_number, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, node_number, coord_x, coord_y, coord_z, output ready);
endinterface

interface tes_ent_if;
    logic                              valid;
    logic                              ready;
    logic [tes_pkg::NODE_W-1:0]        row_node;
    logic [tes_pkg::NODE_W-1:0]        col_node;
    logic signed [tes_pkg::VAL_W-1:0]  entry_value;
    logic                              degenerate;
    logic                              last_entry;

    modport source (output valid, row_node, col_node, entry_value, degenerate, last_entry,
                    input ready);
    modport sink   (input valid, row_node, col_node, entry_value, degenerate, last_entry,
                    output ready);
endinterface

// ===== rtl/tes_front.sv =====
// Vertex collector plus a two-deep element queue toward the compute side.
module tes_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tes_vtx_if.sink         i_vtx,
    output logic            o_elem_valid,
    input  logic            i_elem_ready,
    output tes_pkg::t_elem  o_elem
);

    logic [1:0]                     r_cnt;
    logic [tes_pkg::NODE_W-1:0]     r_node [3];
    logic [tes_pkg::COORD_W-1:0]    r_x [3];
    logic [tes_pkg::COORD_W-1:0]    r_y [3];
    logic [tes_pkg::COORD_W-1:0]    r_z [3];

    tes_pkg::t_elem                 r_q [2];
    logic                           r_wp;
    logic                           r_rp;
    logic [1:0]                     r_qcnt;

    tes_pkg::t_elem                 n_elem;
    logic                           w_acc;
    logic                           w_push;
    logic                           w_pop;

    assign i_vtx.ready  = (r_cnt != 2'd3) || (r_qcnt != 2'd2);
    assign w_acc        = i_vtx.valid && i_vtx.ready;
    assign w_push       = w_acc && (r_cnt == 2'd3);
    assign o_elem_valid = (r_qcnt != 2'd0);
    assign w_pop        = o_elem_valid && i_elem_ready;
    assign o_elem       = r_q[r_rp];

    // assemble element from three stored vertices and the current beat
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            n_elem.nodes[v]      = r_node[v];
            n_elem.coords[v*3]   = r_x[v];
            n_elem.coords[v*3+1] = r_y[v];
            n_elem.coords[v*3+2] = r_z[v];
        end
        n_elem.nodes[3]   = i_vtx.node_number;
        n_elem.coords[9]  = i_vtx.coord_x;
        n_elem.coords[10] = i_vtx.coord_y;
        n_elem.coords[11] = i_vtx.coord_z;
    end

    // vertex store
    always_ff @(posedge i_clk) begin
        if (w_acc && (r_cnt != 2'd3)) begin
            r_node[r_cnt] <= i_vtx.node_number;
            r_x[r_cnt]    <= i_vtx.coord_x;
            r_y[r_cnt]    <= i_vtx.coord_y;
            r_z[r_cnt]    <= i_vtx.coord_z;
        end
        if (w_push) begin
            r_q[r_wp] <= n_elem;
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            if (w_acc) r_cnt <= r_cnt + 2'd1;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            if (w_push && !w_pop) r_qcnt <= r_qcnt + 2'd1;
            else if (!w_push && w_pop) r_qcnt <= r_qcnt - 2'd1;
        end
    end

endmodule

// ===== rtl/tes_mul.sv =====
// Shift-add signed multiplier, one B bit per cycle, B sign bit weighted negative.
module tes_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tes_pkg::t_mul_req  i_req,
    output tes_pkg::t_mul_rsp  o_rsp
);

    localparam int CNT_W = $clog2(tes_pkg::OPB_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [tes_pkg::PROD_W-1:0]    r_a;
    logic [tes_pkg::OPB_W-1:0]     r_b;
    logic [tes_pkg::PROD_W-1:0]    r_p;
    logic [tes_pkg::PROD_W-1:0]    w_pp;
    logic                          w_last;

    assign w_pp   = r_b[0] ? r_a : '0;
    assign w_last = (r_cnt == CNT_W'(tes_pkg::OPB_W - 1));

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= {{(tes_pkg::PROD_W - tes_pkg::OPA_W){i_req.a[tes_pkg::OPA_W-1]}}, i_req.a};
            r_b <= i_req.b;
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= w_last ? (r_p - w_pp) : (r_p + w_pp);
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

// ===== rtl/tes_div.sv =====
// Restoring divider: 64 quotient bits, one per cycle, with an up-front overflow test.
module tes_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tes_pkg::t_div_req  i_req,
    output tes_pkg::t_div_rsp  o_rsp
);

    localparam int HI_W  = tes_pkg::PROD_W - tes_pkg::Q_W;
    localparam int CNT_W = $clog2(tes_pkg::Q_W);

    logic                         r_busy;
    logic                         r_done;
    logic                         r_sat;
    logic [CNT_W-1:0]             r_cnt;
    logic [tes_pkg::DEN_W-1:0]    r_rem;
    logic [tes_pkg::DEN_W-1:0]    r_den2;
    logic [tes_pkg::Q_W-1:0]      r_lq;   // low dividend bits shift out, quotient bits in
    logic                         w_ovf;
    logic [tes_pkg::DEN_W:0]      w_trial;
    logic                         w_ge;

    assign w_ovf   = i_req.mag[tes_pkg::PROD_W-1:tes_pkg::Q_W] >= HI_W'(i_req.den2);
    assign w_trial = {r_rem, r_lq[tes_pkg::Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den2};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.mag[tes_pkg::Q_W +: tes_pkg::DEN_W];
            r_lq   <= i_req.mag[tes_pkg::Q_W-1:0];
            r_den2 <= i_req.den2;
            r_sat  <= w_ovf;
        end else if (r_busy) begin
            r_rem <= w_ge ? tes_pkg::DEN_W'(w_trial - {1'b0, r_den2})
                          : tes_pkg::DEN_W'(w_trial);
            r_lq  <= {r_lq[tes_pkg::Q_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= '0;
                if (w_ovf) r_done <= 1'b1;
                else r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(tes_pkg::Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.q    = r_lq;

endmodule

// ===== rtl/tes_back.sv =====
// Element sequencer: edge vectors, adjugate, determinant, then 16 entries.
module tes_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_elem_valid,
    output logic                        o_elem_ready,
    input  tes_pkg::t_elem              i_elem,
    input  logic [tes_pkg::COEF_W-1:0]  i_coef,
    output tes_pkg::t_mul_req           o_mul_req,
    input  tes_pkg::t_mul_rsp           i_mul_rsp,
    output tes_pkg::t_div_req           o_div_req,
    input  tes_pkg::t_div_rsp           i_div_rsp,
    tes_ent_if.source                   o_ent
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_CROSS = 4'd2;
    localparam logic [3:0] S_A3    = 4'd3;
    localparam logic [3:0] S_DET   = 4'd4;
    localparam logic [3:0] S_DEN   = 4'd5;
    localparam logic [3:0] S_DOT   = 4'd6;
    localparam logic [3:0] S_COEF  = 4'd7;
    localparam logic [3:0] S_MAG   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    localparam int AW = tes_pkg::FILE_AW;
    localparam int BW = tes_pkg::OPB_W;
    localparam int PW = tes_pkg::PROD_W;

    // flat index row*3+col
    function automatic logic [AW-1:0] f_idx(input logic [1:0] row, input logic [1:0] col);
        logic [AW-1:0] r;
        r = (AW'(row) << 1) + AW'(row) + AW'(col);
        return r;
    endfunction

    logic [3:0]                    r_state;
    logic [1:0]                    r_ph;
    logic [1:0]                    r_j;
    logic [1:0]                    r_k;
    logic [1:0]                    r_i;
    logic                          r_t;
    logic [3:0]                    r_n;
    logic [1:0]                    r_ax;

    logic [tes_pkg::COORD_W-1:0]   r_xyz [9];
    logic [tes_pkg::COORD_W-1:0]   r_p3 [3];
    logic [tes_pkg::NODE_W-1:0]    r_rnode [4];
    logic [tes_pkg::NODE_W-1:0]    r_cnode [4];

    logic [BW-1:0]                 r_file [tes_pkg::FILE_DEPTH];
    logic [BW-1:0]                 r_rd;
    logic [BW-1:0]                 r_opa;
    logic [BW-1:0]                 r_s [3];
    logic [PW-1:0]                 r_acc;
    logic [tes_pkg::DEN_W-1:0]     r_den;
    logic                          r_degen;
    logic                          r_neg;
    logic [PW-1:0]                 r_mag;
    logic [tes_pkg::VAL_W-1:0]     r_val;

    logic                          r_ov;
    logic [tes_pkg::NODE_W-1:0]    r_orow;
    logic [tes_pkg::NODE_W-1:0]    r_ocol;
    logic [tes_pkg::VAL_W-1:0]     r_oval;
    logic                          r_odeg;
    logic                          r_olast;

    logic [AW-1:0]                 w_raddr;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [BW-1:0]                 w_wdata;
    logic                          w_first;
    logic                          w_sub;
    logic [PW-1:0]                 n_acc;
    logic [1:0]                    w_p;
    logic [1:0]                    w_q;
    logic [1:0]                    w_u;
    logic [1:0]                    w_v;
    logic [tes_pkg::DIFF_W-1:0]    w_diff;
    logic [tes_pkg::DET_W-1:0]     w_det;
    logic [tes_pkg::DET_W-1:0]     w_absd;
    logic [PW-1:0]                 w_absn;
    logic [tes_pkg::VAL_W-1:0]     n_val;
    logic                          w_out_free;
    logic                          w_take;
    logic                          w_mul_state;

    assign w_p = tes_pkg::f_inc3(r_j);
    assign w_q = tes_pkg::f_inc3(w_p);
    assign w_u = tes_pkg::f_inc3(r_i);
    assign w_v = tes_pkg::f_inc3(w_u);

    assign o_elem_ready = (r_state == S_IDLE);
    assign w_take       = i_elem_valid && o_elem_ready;
    assign w_out_free   = !r_ov || o_ent.ready;
    assign w_mul_state  = (r_state == S_CROSS) || (r_state == S_DET) || (r_state == S_DOT);

    // operand read address: A in phase 0, B afterwards
    always_comb begin
        case (r_state)
            S_CROSS: begin
                if (r_ph == 2'd0) w_raddr = r_t ? f_idx(w_p, w_v) : f_idx(w_p, w_u);
                else w_raddr = r_t ? f_idx(w_q, w_u) : f_idx(w_q, w_v);
            end
            S_DET: begin
                if (r_ph == 2'd0) w_raddr = AW'(r_i);
                else w_raddr = AW'(tes_pkg::ADJ_BASE) + AW'(r_i);
            end
            S_DOT: begin
                if (r_ph == 2'd0) w_raddr = AW'(tes_pkg::ADJ_BASE) + f_idx(r_j, r_i);
                else w_raddr = AW'(tes_pkg::ADJ_BASE) + f_idx(r_k, r_i);
            end
            default: w_raddr = '0;
        endcase
    end

    // edge vector component c = p_n - p_3
    assign w_diff = {r_xyz[r_n][tes_pkg::COORD_W-1], r_xyz[r_n]}
                  - {r_p3[r_ax][tes_pkg::COORD_W-1], r_p3[r_ax]};

    // register file write
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        case (r_state)
            S_LOAD: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_n);
                w_wdata = {{(BW - tes_pkg::DIFF_W){w_diff[tes_pkg::DIFF_W-1]}}, w_diff};
            end
            S_CROSS: begin
                w_we    = (r_ph == 2'd3) && i_mul_rsp.done && r_t;
                w_waddr = AW'(tes_pkg::ADJ_BASE) + f_idx(r_j, r_i);
                w_wdata = n_acc[BW-1:0];
            end
            S_A3: begin
                w_we    = 1'b1;
                w_waddr = AW'(tes_pkg::ADJ3_BASE) + AW'(r_i);
                w_wdata = BW'(0) - r_s[r_i];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_file[w_waddr] <= w_wdata;
        r_rd <= r_file[w_raddr];
    end

    // accumulate products
    assign w_first = (r_state == S_COEF) || ((r_state == S_CROSS) ? !r_t : (r_i == 2'd0));
    assign w_sub   = (r_state == S_CROSS) && r_t;
    always_comb begin
        n_acc = w_first ? '0 : r_acc;
        n_acc = w_sub ? (n_acc - i_mul_rsp.p) : (n_acc + i_mul_rsp.p);
    end

    // multiplier request
    always_comb begin
        o_mul_req.start = (w_mul_state && (r_ph == 2'd2))
                        || ((r_state == S_COEF) && (r_ph == 2'd0));
        if (r_state == S_COEF) begin
            o_mul_req.a = r_acc[tes_pkg::OPA_W-1:0];
            o_mul_req.b = {{(BW - tes_pkg::COEF_W){i_coef[tes_pkg::COEF_W-1]}}, i_coef};
        end else begin
            o_mul_req.a = {{(tes_pkg::OPA_W - BW){r_opa[BW-1]}}, r_opa};
            o_mul_req.b = r_rd;
        end
    end

    assign o_div_req.start = (r_state == S_DIV) && (r_ph == 2'd0);
    assign o_div_req.mag   = r_mag;
    assign o_div_req.den2  = r_den << 1;

    // determinant magnitude, numerator magnitude
    assign w_det  = r_acc[tes_pkg::DET_W-1:0];
    assign w_absd = w_det[tes_pkg::DET_W-1] ? (tes_pkg::DET_W'(0) - w_det) : w_det;
    assign w_absn = r_acc[PW-1] ? (PW'(0) - r_acc) : r_acc;

    // round-to-nearest quotient to saturated signed value
    always_comb begin
        if (r_neg) begin
            if (i_div_rsp.sat || (i_div_rsp.q > tes_pkg::VAL_MIN)) n_val = tes_pkg::VAL_MIN;
            else n_val = tes_pkg::VAL_W'(0) - i_div_rsp.q;
        end else begin
            if (i_div_rsp.sat || i_div_rsp.q[tes_pkg::Q_W-1]) n_val = tes_pkg::VAL_MAX;
            else n_val = i_div_rsp.q;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    for (int m = 0; m < 9; m++) r_xyz[m] <= i_elem.coords[m];
                    for (int m = 0; m < 3; m++) r_p3[m] <= i_elem.coords[9+m];
                    for (int m = 0; m < 4; m++) begin
                        r_rnode[m] <= i_elem.nodes[m];
                        r_cnode[m] <= i_elem.nodes[m];
                    end
                end
            end
            S_CROSS: begin
                if (r_ph == 2'd1) r_opa <= r_rd;
                if ((r_ph == 2'd3) && i_mul_rsp.done) begin
                    r_acc <= n_acc;
                    if (r_t) r_s[r_i] <= ((r_j == 2'd0) ? BW'(0) : r_s[r_i]) + n_acc[BW-1:0];
                end
            end
            S_DET, S_DOT: begin
                if (r_ph == 2'd1) r_opa <= r_rd;
                if ((r_ph == 2'd3) && i_mul_rsp.done) r_acc <= n_acc;
            end
            S_DEN: begin
                r_degen <= (w_det == '0);
                r_den   <= (tes_pkg::DEN_W'(w_absd) << 2) + (tes_pkg::DEN_W'(w_absd) << 1);
            end
            S_COEF: begin
                if ((r_ph == 2'd1) && i_mul_rsp.done) r_acc <= n_acc;
            end
            S_MAG: begin
                r_neg <= r_acc[PW-1];
                r_mag <= (w_absn << 1) + PW'(r_den);
            end
            S_DIV: begin
                if ((r_ph == 2'd1) && i_div_rsp.done) r_val <= n_val;
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 2'd0;
            r_j     <= 2'd0;
            r_k     <= 2'd0;
            r_i     <= 2'd0;
            r_t     <= 1'b0;
            r_n     <= 4'd0;
            r_ax    <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_state <= S_LOAD;
                        r_n     <= 4'd0;
                        r_ax    <= 2'd0;
                    end
                end
                S_LOAD: begin
                    r_n  <= r_n + 4'd1;
                    r_ax <= tes_pkg::f_inc3(r_ax);
                    if (r_n == 4'd8) begin
                        r_state <= S_CROSS;
                        r_j     <= 2'd0;
                        r_i     <= 2'd0;
                        r_t     <= 1'b0;
                        r_ph    <= 2'd0;
                    end
                end
                S_CROSS: begin
                    if (r_ph != 2'd3) r_ph <= r_ph + 2'd1;
                    else if (i_mul_rsp.done) begin
                        r_ph <= 2'd0;
                        r_t  <= ~r_t;
                        if (r_t) begin
                            if (r_i == 2'd2) begin
                                r_i <= 2'd0;
                                if (r_j == 2'd2) begin
                                    r_j     <= 2'd0;
                                    r_state <= S_A3;
                                end else begin
                                    r_j <= r_j + 2'd1;
                                end
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end
                    end
                end
                S_A3: begin
                    if (r_i == 2'd2) begin
                        r_i     <= 2'd0;
                        r_ph    <= 2'd0;
                        r_state <= S_DET;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
                S_DET: begin
                    if (r_ph != 2'd3) r_ph <= r_ph + 2'd1;
                    else if (i_mul_rsp.done) begin
                        r_ph <= 2'd0;
                        if (r_i == 2'd2) begin
                            r_i     <= 2'd0;
                            r_state <= S_DEN;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                S_DEN: begin
                    r_j     <= 2'd0;
                    r_k     <= 2'd0;
                    r_ph    <= 2'd0;
                    r_state <= (w_det == '0) ? S_EMIT : S_DOT;
                end
                S_DOT: begin
                    if (r_ph != 2'd3) r_ph <= r_ph + 2'd1;
                    else if (i_mul_rsp.done) begin
                        r_ph <= 2'd0;
                        if (r_i == 2'd2) begin
                            r_i     <= 2'd0;
                            r_state <= S_COEF;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                S_COEF: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (i_mul_rsp.done) begin
                        r_ph    <= 2'd0;
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_ph    <= 2'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (i_div_rsp.done) begin
                        r_ph    <= 2'd0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) r_j <= r_j + 2'd1;
                        if ((r_j == 2'd3) && (r_k == 2'd3)) r_state <= S_IDLE;
                        else r_state <= r_degen ? S_EMIT : S_DOT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register, loads when empty or while the previous beat is being taken
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_orow  <= r_rnode[r_j];
            r_ocol  <= r_cnode[r_k];
            r_oval  <= r_degen ? '0 : r_val;
            r_odeg  <= r_degen;
            r_olast <= (r_j == 2'd3) && (r_k == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && w_out_free) r_ov <= 1'b1;
            else if (o_ent.ready) r_ov <= 1'b0;
        end
    end

    assign o_ent.valid       = r_ov;
    assign o_ent.row_node    = r_orow;
    assign o_ent.col_node    = r_ocol;
    assign o_ent.entry_value = r_oval;
    assign o_ent.degenerate  = r_odeg;
    assign o_ent.last_entry  = r_olast;

endmodule

// ===== rtl/tet_element_stiffness_unit.sv =====
// Linear tetrahedron element stiffness: four vertex beats in, sixteen entry beats out
// (row-major, row node outer). The first three vertices of an element are always
// accepted; the fourth queues the element for the compute side, and up to two elements
// wait in that queue while it works. A non-degenerate element runs 85 products through
// a 72-step shift-add multiplier, plus sixteen 64-step divisions. A degenerate element
// (zero determinant) skips the dot products, coefficient scaling and divisions, and so
// finishes early. The coefficient is read live, so write it only when idle.
`include "tet_element_stiffness_unit_defines.svh"

module tet_element_stiffness_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [tes_pkg::COEF_W-1:0]  i_cfg_wr_data,
    tes_vtx_if.sink                     i_vtx,
    tes_ent_if.source                   o_ent
);

    logic [tes_pkg::COEF_W-1:0]  r_coef;
    logic                        w_elem_valid;
    logic                        w_elem_ready;
    tes_pkg::t_elem              w_elem;
    tes_pkg::t_mul_req           w_mul_req;
    tes_pkg::t_mul_rsp           w_mul_rsp;
    tes_pkg::t_div_req           w_div_req;
    tes_pkg::t_div_rsp           w_div_rsp;

    // coefficient register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= tes_pkg::COEF_RESET;
        end else if (i_cfg_wr_en) begin
            r_coef <= i_cfg_wr_data;
        end
    end

    tes_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (i_vtx),
        .o_elem_valid (w_elem_valid),
        .i_elem_ready (w_elem_ready),
        .o_elem       (w_elem)
    );

    tes_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    tes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    tes_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_valid (w_elem_valid),
        .o_elem_ready (w_elem_ready),
        .i_elem       (w_elem),
        .i_coef       (r_coef),
        .o_mul_req    (w_mul_req),
        .i_mul_rsp    (w_mul_rsp),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp),
        .o_ent        (o_ent)
    );

    // multiplier is started once per operand pair, never back to back
    `TES_ASSERT_NEXT(a_mul_single_start, w_mul_req.start, !w_mul_req.start)
    // the two arithmetic units never finish together
    `TES_ASSERT_NOW(a_units_exclusive, w_mul_rsp.done, !w_div_rsp.done)
    // degenerate entries carry a zero value
    `TES_ASSERT_NOW(a_degen_zero, o_ent.valid && o_ent.degenerate, o_ent.entry_value == '0)

endmodule
